@@ hw/rtl/arf_pkg.sv @@
// Shared types and constants for the advertising report filter.
package arf_pkg;

    localparam logic [7:0] AD_UUID16_COMPLETE = 8'h03;
    localparam logic [7:0] AD_MANUF = 8'hFF;
    localparam logic signed [7:0] RSSI_THRESHOLD_RESET = -8'sd70;
    localparam logic [15:0] WANTED_UUID_RESET = 16'h0000;

    typedef enum logic [1:0] {
        OP_DATA = 2'd0,
        OP_FREE = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        VERDICT_WEAK    = 3'd0,
        VERDICT_NO_UUID = 3'd1,
        VERDICT_NO_SER  = 3'd2,
        VERDICT_FULL    = 3'd3,
        VERDICT_STORED  = 3'd4,
        VERDICT_NONE    = 3'd5
    } verdict_t;

    typedef enum logic [1:0] {
        CFG_RSSI_THRESHOLD = 2'd0,
        CFG_WANTED_UUID    = 2'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_TYPE = 2'd1,
        PH_VAL  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        SEEN_NONE  = 2'd0,
        SEEN_CAPT  = 2'd1,
        SEEN_DONE  = 2'd2,
        SEEN_SHORT = 2'd3
    } seen_t;

    typedef enum logic {
        KIND_VERDICT = 1'b0,
        KIND_READ    = 1'b1
    } result_kind_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         data_byte;
        logic               last_byte;
        logic signed [7:0]  report_rssi;
        logic [47:0]        peer_address;
        logic [1:0]         peer_address_type;
        logic [2:0]         slot_select;
    } in_word_t;

    typedef struct packed {
        logic               result_kind;
        logic [2:0]         verdict;
        logic [2:0]         slot_index;
        logic [31:0]        serial_number;
        logic signed [7:0]  entry_rssi;
        logic [47:0]        entry_address;
        logic [1:0]         entry_address_type;
        logic               entry_occupied;
    } out_word_t;

    // Captures as they stand after the current byte is parsed
    typedef struct packed {
        logic        uuid_done;
        logic [15:0] uuid;
        logic        serial_done;
        logic [31:0] serial;
    } capture_t;

    typedef struct packed {
        logic [31:0]        serial;
        logic signed [7:0]  rssi;
        logic [47:0]        address;
        logic [1:0]         address_type;
    } entry_t;

endpackage

@@ hw/rtl/arf_parser.sv @@
// Length-type-value walker that captures the service UUID and the serial.
module arf_parser
    import arf_pkg::*;
#(
    parameter int SERIAL_BYTES = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_en,
    input  logic       last_byte,
    input  logic [7:0] data_byte,
    output capture_t   cap
);

    logic [7:0]  left_reg, left_next, left_dec;
    phase_t      phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  offset_reg, offset_next;
    logic [15:0] uuid_reg, uuid_next;
    seen_t       uuid_seen_reg, uuid_seen_next;
    logic [31:0] serial_reg, serial_next;
    seen_t       serial_seen_reg, serial_seen_next;

    always_comb
    begin
        left_next        = left_reg;
        phase_next       = phase_reg;
        type_next        = type_reg;
        offset_next      = offset_reg;
        uuid_next        = uuid_reg;
        uuid_seen_next   = uuid_seen_reg;
        serial_next      = serial_reg;
        serial_seen_next = serial_seen_reg;
        left_dec         = left_reg - 8'd1;
        if (byte_en)
        begin
            case (phase_reg)
                PH_TYPE:
                begin
                    type_next   = data_byte;
                    left_next   = left_dec;
                    offset_next = 8'd0;
                    if (data_byte == AD_UUID16_COMPLETE && uuid_seen_reg == SEEN_NONE)
                    begin
                        uuid_seen_next = (left_dec >= 8'd2) ? SEEN_CAPT : SEEN_SHORT;
                    end
                    if (data_byte == AD_MANUF && serial_seen_reg == SEEN_NONE)
                    begin
                        serial_seen_next = (left_dec >= 8'(SERIAL_BYTES)) ?
                                           SEEN_CAPT : SEEN_SHORT;
                    end
                    phase_next = (left_dec == 8'd0) ? PH_LEN : PH_VAL;
                end
                PH_VAL:
                begin
                    if (type_reg == AD_UUID16_COMPLETE && uuid_seen_reg == SEEN_CAPT)
                    begin
                        if (offset_reg == 8'd0)
                        begin
                            uuid_next = {8'd0, data_byte};
                        end
                        else if (offset_reg == 8'd1)
                        begin
                            uuid_next      = {data_byte, uuid_reg[7:0]};
                            uuid_seen_next = SEEN_DONE;
                        end
                    end
                    if (type_reg == AD_MANUF && serial_seen_reg == SEEN_CAPT &&
                        offset_reg < 8'(SERIAL_BYTES))
                    begin
                        serial_next = {serial_reg[23:0], data_byte};
                        if (offset_reg == 8'(SERIAL_BYTES - 1))
                        begin
                            serial_seen_next = SEEN_DONE;
                        end
                    end
                    offset_next = offset_reg + 8'd1;
                    left_next   = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        phase_next = PH_LEN;
                    end
                end
                default:
                begin
                    left_next  = data_byte;
                    phase_next = (data_byte == 8'd0) ? PH_LEN : PH_TYPE;
                end
            endcase
        end
    end

    assign cap.uuid_done   = (uuid_seen_next == SEEN_DONE);
    assign cap.uuid        = uuid_next;
    assign cap.serial_done = (serial_seen_next == SEEN_DONE);
    assign cap.serial      = serial_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg        <= 8'd0;
            phase_reg       <= PH_LEN;
            type_reg        <= 8'd0;
            offset_reg      <= 8'd0;
            uuid_reg        <= 16'd0;
            uuid_seen_reg   <= SEEN_NONE;
            serial_reg      <= 32'd0;
            serial_seen_reg <= SEEN_NONE;
        end
        else if (byte_en && last_byte)
        begin
            // end of report: back to the idle parser
            left_reg        <= 8'd0;
            phase_reg       <= PH_LEN;
            type_reg        <= 8'd0;
            offset_reg      <= 8'd0;
            uuid_reg        <= 16'd0;
            uuid_seen_reg   <= SEEN_NONE;
            serial_reg      <= 32'd0;
            serial_seen_reg <= SEEN_NONE;
        end
        else
        begin
            left_reg        <= left_next;
            phase_reg       <= phase_next;
            type_reg        <= type_next;
            offset_reg      <= offset_next;
            uuid_reg        <= uuid_next;
            uuid_seen_reg   <= uuid_seen_next;
            serial_reg      <= serial_next;
            serial_seen_reg <= serial_seen_next;
        end
    end

endmodule

@@ hw/rtl/adv_report_filter_top.sv @@
// Advertising report filter: parser, verdict logic and device slot table.
//
//   channel  direction  handshake            word
//   in       input      in_valid / in_stall  in_word (in_word_t)
//   out      output     out_valid/ out_stall out_word (out_word_t)
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// A word is registered in the input register on acceptance and processed from there into
// the result register.
// One word is taken per cycle while the result side is not stalled; the slot
// table has one write port and one read port that is read as a word enters.
// Reset clears the parser, the result valid and the slot occupied bits; the
// slot contents stay undefined until stored. An out stall holds the result
// register and, once the input register is also full, raises in_stall.
module adv_report_filter_top
    import arf_pkg::*;
#(
    parameter int SLOTS        = 8,
    parameter int SERIAL_BYTES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_word,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_word,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic signed [7:0] rssi_threshold_reg;
    logic [15:0]       wanted_uuid_reg;

    logic              s1_valid_reg;
    in_word_t          s1_reg;
    entry_t            rd_entry_reg;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_reg, out_next;

    logic [SLOTS-1:0]  occ_reg, occ_next;
    entry_t            mem [SLOTS];

    logic              accept, move, out_ready, has_result;
    logic              byte_en, mem_we;
    logic [SLOT_W-1:0] s1_idx, in_idx, free_idx;
    logic              s1_in_range, free_found;
    entry_t            wr_entry;
    capture_t          cap;
    logic [31:0]       serial;
    verdict_t          verdict;

    assign out_ready = !out_valid_reg || !out_stall;
    assign move      = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign accept    = in_valid && !in_stall;

    assign s1_idx      = SLOT_W'(s1_reg.slot_select);
    assign in_idx      = SLOT_W'(in_word.slot_select);
    assign s1_in_range = ({29'd0, s1_reg.slot_select} < 32'(SLOTS));
    assign byte_en     = move && (s1_reg.opcode == OP_DATA);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rssi_threshold_reg <= RSSI_THRESHOLD_RESET;
            wanted_uuid_reg    <= WANTED_UUID_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_RSSI_THRESHOLD)
            begin
                rssi_threshold_reg <= cfg_data[7:0];
            end
            else if (cfg_index == CFG_WANTED_UUID)
            begin
                wanted_uuid_reg <= cfg_data;
            end
        end
    end

    arf_parser #(
        .SERIAL_BYTES(SERIAL_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (byte_en),
        .last_byte (s1_reg.last_byte),
        .data_byte (s1_reg.data_byte),
        .cap       (cap)
    );

    // lowest free slot
    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!occ_reg[i])
            begin
                free_idx   = SLOT_W'(i);
                free_found = 1'b1;
            end
        end
    end

    assign serial = cap.serial_done ? cap.serial : 32'd0;

    always_comb
    begin
        if (s1_reg.report_rssi <= rssi_threshold_reg)
        begin
            verdict = VERDICT_WEAK;
        end
        else if (!cap.uuid_done || cap.uuid != wanted_uuid_reg)
        begin
            verdict = VERDICT_NO_UUID;
        end
        else if (serial == 32'd0)
        begin
            verdict = VERDICT_NO_SER;
        end
        else if (!free_found)
        begin
            verdict = VERDICT_FULL;
        end
        else
        begin
            verdict = VERDICT_STORED;
        end
    end

    assign wr_entry.serial       = serial;
    assign wr_entry.rssi         = s1_reg.report_rssi;
    assign wr_entry.address      = s1_reg.peer_address;
    assign wr_entry.address_type = s1_reg.peer_address_type;

    always_comb
    begin
        occ_next   = occ_reg;
        has_result = 1'b0;
        mem_we     = 1'b0;
        out_next   = out_reg;
        case (s1_reg.opcode)
            OP_FREE:
            begin
                if (s1_in_range)
                begin
                    occ_next[s1_idx] = 1'b0;
                end
            end
            OP_READ:
            begin
                has_result                  = 1'b1;
                out_next.result_kind        = KIND_READ;
                out_next.verdict            = VERDICT_NONE;
                out_next.slot_index         = s1_reg.slot_select;
                out_next.serial_number      = 32'd0;
                out_next.entry_rssi         = 8'sd0;
                out_next.entry_address      = 48'd0;
                out_next.entry_address_type = 2'd0;
                out_next.entry_occupied     = 1'b0;
                if (s1_in_range && occ_reg[s1_idx])
                begin
                    out_next.serial_number      = rd_entry_reg.serial;
                    out_next.entry_rssi         = rd_entry_reg.rssi;
                    out_next.entry_address      = rd_entry_reg.address;
                    out_next.entry_address_type = rd_entry_reg.address_type;
                    out_next.entry_occupied     = 1'b1;
                end
            end
            OP_DATA:
            begin
                if (s1_reg.last_byte)
                begin
                    has_result                  = 1'b1;
                    out_next.result_kind        = KIND_VERDICT;
                    out_next.verdict            = verdict;
                    out_next.slot_index         = 3'd0;
                    out_next.serial_number      = serial;
                    out_next.entry_rssi         = s1_reg.report_rssi;
                    out_next.entry_address      = s1_reg.peer_address;
                    out_next.entry_address_type = s1_reg.peer_address_type;
                    out_next.entry_occupied     = 1'b0;
                    if (verdict == VERDICT_STORED)
                    begin
                        mem_we                  = 1'b1;
                        occ_next[free_idx]      = 1'b1;
                        out_next.slot_index     = 3'(free_idx);
                        out_next.entry_occupied = 1'b1;
                    end
                end
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (move && has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            occ_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                s1_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
            if (move)
            begin
                occ_reg <= occ_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= in_word;
        end
        if (move && has_result)
        begin
            out_reg <= out_next;
        end
    end

    // Slot table: write from the word leaving the input register, read as a
    // new word enters; forward a same-cycle write to the read.
    always_ff @(posedge clk)
    begin
        if (move && mem_we)
        begin
            mem[free_idx] <= wr_entry;
        end
        if (accept)
        begin
            if (move && mem_we && free_idx == in_idx)
            begin
                rd_entry_reg <= wr_entry;
            end
            else
            begin
                rd_entry_reg <= mem[in_idx];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

@@ bench/adv_report_filter_checker.sv @@
// Checker for the advertising report filter: tracks accepted words and compares results.
module adv_report_filter_checker
    import arf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  in_word_t    in_word,
    input  logic        out_valid,
    input  logic        out_stall,
    input  out_word_t   out_word,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          mismatches,
    output int          answers_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = 8;
    localparam int SERIAL_BYTES = 4;
    localparam int PRINT_LIMIT  = 100;

    logic signed [7:0] threshold;
    logic [15:0]       target_uuid;

    logic [7:0]        bytes_left;
    phase_t            phase;
    logic [7:0]        ad_type;
    logic [7:0]        field_offset;
    logic [15:0]       uuid_value;
    seen_t             uuid_state;
    logic [31:0]       serial_value;
    seen_t             serial_state;

    logic [SLOTS-1:0]  occupied;
    entry_t            slot_entry [SLOTS];

    out_word_t         filter_answers [$];
    out_word_t         due;
    int                fail_count = 0;

    assign mismatches = fail_count;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
        begin
            $display("%0t: mismatch: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic clear_parser();
        bytes_left   = '0;
        phase        = PH_LEN;
        ad_type      = '0;
        field_offset = '0;
        uuid_value   = '0;
        uuid_state   = SEEN_NONE;
        serial_value = '0;
        serial_state = SEEN_NONE;
    endtask

    task automatic parse_adv_byte(input logic [7:0] b);
        case (phase)
            PH_TYPE:
            begin
                ad_type      = b;
                bytes_left   = bytes_left - 8'd1;
                field_offset = '0;
                // only the first structure of each kind is looked at
                if (b == AD_UUID16_COMPLETE && uuid_state == SEEN_NONE)
                begin
                    uuid_state = (bytes_left >= 2) ? SEEN_CAPT : SEEN_SHORT;
                end
                if (b == AD_MANUF && serial_state == SEEN_NONE)
                begin
                    serial_state = (bytes_left >= SERIAL_BYTES) ? SEEN_CAPT : SEEN_SHORT;
                end
                phase = (bytes_left == 0) ? PH_LEN : PH_VAL;
            end
            PH_VAL:
            begin
                if (ad_type == AD_UUID16_COMPLETE && uuid_state == SEEN_CAPT)
                begin
                    if (field_offset == 0)
                    begin
                        uuid_value = {8'h00, b};
                    end
                    else if (field_offset == 1)
                    begin
                        uuid_value[15:8] = b;
                        uuid_state       = SEEN_DONE;
                    end
                end
                // serial is big-endian: shift in from the bottom
                if (ad_type == AD_MANUF && serial_state == SEEN_CAPT &&
                    field_offset < SERIAL_BYTES)
                begin
                    serial_value = {serial_value[23:0], b};
                    if (field_offset == SERIAL_BYTES - 1)
                    begin
                        serial_state = SEEN_DONE;
                    end
                end
                field_offset = field_offset + 8'd1;
                bytes_left   = bytes_left - 8'd1;
                if (bytes_left == 0)
                begin
                    phase = PH_LEN;
                end
            end
            default:
            begin
                bytes_left = b;
                phase      = (b == 0) ? PH_LEN : PH_TYPE;
            end
        endcase
    endtask

    task automatic apply_filter_word(input in_word_t w);
        out_word_t   ans;
        logic [31:0] serial;
        int          free_slot;

        ans = '0;
        case (w.opcode)
            OP_FREE:
            begin
                occupied[w.slot_select] = 1'b0;
            end
            OP_READ:
            begin
                ans.result_kind = KIND_READ;
                ans.verdict     = VERDICT_NONE;
                ans.slot_index  = w.slot_select;
                if (occupied[w.slot_select])
                begin
                    ans.serial_number      = slot_entry[w.slot_select].serial;
                    ans.entry_rssi         = slot_entry[w.slot_select].rssi;
                    ans.entry_address      = slot_entry[w.slot_select].address;
                    ans.entry_address_type = slot_entry[w.slot_select].address_type;
                    ans.entry_occupied     = 1'b1;
                end
                filter_answers.push_back(ans);
            end
            OP_DATA:
            begin
                parse_adv_byte(w.data_byte);
                if (w.last_byte)
                begin
                    serial    = (serial_state == SEEN_DONE) ? serial_value : '0;
                    free_slot = -1;
                    for (int i = SLOTS - 1; i >= 0; i--)
                    begin
                        if (!occupied[i])
                        begin
                            free_slot = i;
                        end
                    end
                    ans.result_kind        = KIND_VERDICT;
                    ans.serial_number      = serial;
                    ans.entry_rssi         = w.report_rssi;
                    ans.entry_address      = w.peer_address;
                    ans.entry_address_type = w.peer_address_type;
                    // checks in priority order: signal, uuid, serial, room
                    if ($signed(w.report_rssi) <= $signed(threshold))
                    begin
                        ans.verdict = VERDICT_WEAK;
                    end
                    else if (uuid_state != SEEN_DONE || uuid_value != target_uuid)
                    begin
                        ans.verdict = VERDICT_NO_UUID;
                    end
                    else if (serial == 0)
                    begin
                        ans.verdict = VERDICT_NO_SER;
                    end
                    else if (free_slot < 0)
                    begin
                        ans.verdict = VERDICT_FULL;
                    end
                    else
                    begin
                        ans.verdict        = VERDICT_STORED;
                        ans.slot_index     = 3'(free_slot);
                        ans.entry_occupied = 1'b1;
                        occupied[free_slot]                = 1'b1;
                        slot_entry[free_slot].serial       = serial;
                        slot_entry[free_slot].rssi         = w.report_rssi;
                        slot_entry[free_slot].address      = w.peer_address;
                        slot_entry[free_slot].address_type = w.peer_address_type;
                    end
                    filter_answers.push_back(ans);
                    clear_parser();
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold   = RSSI_THRESHOLD_RESET;
            target_uuid = WANTED_UUID_RESET;
            occupied    = '0;
            clear_parser();
            filter_answers.delete();
            answers_owed <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_RSSI_THRESHOLD)
                begin
                    threshold = cfg_data[7:0];
                end
                else if (cfg_index == CFG_WANTED_UUID)
                begin
                    target_uuid = cfg_data;
                end
            end
            if (in_valid && !in_stall)
            begin
                apply_filter_word(in_word);
            end
            if (out_valid && !out_stall)
            begin
                if (filter_answers.size() == 0)
                begin
                    report_mismatch("result word with nothing due");
                end
                else
                begin
                    due = filter_answers.pop_front();
                    check_field("result_kind", {out_word.result_kind}, {due.result_kind});
                    check_field("verdict", {out_word.verdict}, {due.verdict});
                    check_field("slot_index", {out_word.slot_index}, {due.slot_index});
                    check_field("serial_number", {out_word.serial_number},
                                {due.serial_number});
                    check_field("entry_rssi", {out_word.entry_rssi}, {due.entry_rssi});
                    check_field("entry_address", {out_word.entry_address},
                                {due.entry_address});
                    check_field("entry_address_type", {out_word.entry_address_type},
                                {due.entry_address_type});
                    check_field("entry_occupied", {out_word.entry_occupied},
                                {due.entry_occupied});
                end
            end
            answers_owed <= filter_answers.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
// Testbench top for the advertising report filter: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import arf_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int SERIAL_BYTES    = 4;

    typedef enum int {
        FLD_UUID,
        FLD_MANUF,
        FLD_EMPTY,
        FLD_OTHER
    } field_kind_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    in_word_t          in_word    = '0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    out_word_t         out_word;
    logic              cfg_we     = 1'b0;
    logic [1:0]        cfg_index  = '0;
    logic [15:0]       cfg_data   = '0;
    int                mismatches;
    int                answers_owed;

    int                cycles          = 0;
    int                words_sent      = 0;
    int                sender_idle_pct = 0;
    int                stall_pct       = 0;
    logic signed [7:0] cur_threshold   = RSSI_THRESHOLD_RESET;
    logic [15:0]       cur_uuid        = WANTED_UUID_RESET;
    logic signed [7:0] rpt_rssi        = '0;
    logic [47:0]       rpt_address     = '0;
    logic [1:0]        rpt_address_type = '0;
    logic [7:0]        adv_bytes [$];

    adv_report_filter_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    adv_report_filter_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_word      (in_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_word     (out_word),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .answers_owed (answers_owed)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Hold the word until it is taken; idle beforehand at the sender's rate.
    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        words_sent++;
    endtask

    task automatic send_adv_byte(input logic [7:0] b, input logic last);
        in_word_t w;
        w.opcode            = OP_DATA;
        w.data_byte         = b;
        w.last_byte         = last;
        w.report_rssi       = rpt_rssi;
        w.peer_address      = rpt_address;
        w.peer_address_type = rpt_address_type;
        w.slot_select       = 3'($urandom);
        send_word(w);
    endtask

    task automatic send_slot_op(input opcode_t op, input logic [2:0] sel);
        in_word_t w;
        w.opcode            = op;
        w.data_byte         = 8'($urandom);
        w.last_byte         = 1'($urandom);
        w.report_rssi       = 8'($urandom);
        w.peer_address      = rand48();
        w.peer_address_type = 2'($urandom);
        w.slot_select       = sel;
        send_word(w);
    endtask

    // Send the queued report, slipping slot frees and reads in between bytes.
    task automatic send_report(input int slot_op_pct);
        for (int i = 0; i < adv_bytes.size(); i++)
        begin
            if ($urandom_range(99) < slot_op_pct)
            begin
                send_slot_op($urandom_range(1) ? OP_FREE : OP_READ, 3'($urandom));
            end
            send_adv_byte(adv_bytes[i], i == adv_bytes.size() - 1);
        end
    endtask

    task automatic pick_report_source();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
        begin
            rpt_rssi = cur_threshold;
        end
        else if (roll < 25 || cur_threshold == 127)
        begin
            rpt_rssi = 8'($urandom);
        end
        else
        begin
            // strictly above the threshold
            rpt_rssi = cur_threshold + 8'($urandom_range(1, 127 - int'(cur_threshold)));
        end
        rpt_address      = rand48();
        rpt_address_type = 2'($urandom);
    endtask

    task automatic add_uuid_field();
        int          len;
        logic [15:0] uuid;
        len  = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 1 + 2 * $urandom_range(1, 3);
        uuid = ($urandom_range(4) == 0) ? 16'($urandom) : cur_uuid;
        adv_bytes.push_back(8'(len));
        adv_bytes.push_back(AD_UUID16_COMPLETE);
        for (int k = 1; k < len; k++)
        begin
            adv_bytes.push_back(k == 1 ? uuid[7:0] : k == 2 ? uuid[15:8] : 8'($urandom));
        end
    endtask

    task automatic add_manuf_field();
        int          len;
        logic [31:0] serial;
        len    = ($urandom_range(9) == 0) ? $urandom_range(1, SERIAL_BYTES)
                                          : $urandom_range(SERIAL_BYTES + 1, 10);
        serial = ($urandom_range(9) == 0) ? '0 : 32'($urandom);
        adv_bytes.push_back(8'(len));
        adv_bytes.push_back(AD_MANUF);
        for (int k = 1; k < len; k++)
        begin
            adv_bytes.push_back(k <= SERIAL_BYTES ? serial[8 * (SERIAL_BYTES - k) +: 8]
                                                  : 8'($urandom));
        end
    endtask

    task automatic add_other_field();
        int len;
        len = $urandom_range(1, 6);
        adv_bytes.push_back(8'(len));
        adv_bytes.push_back(8'($urandom));
        repeat (len - 1)
        begin
            adv_bytes.push_back(8'($urandom));
        end
    endtask

    // Build a report from structures in random order; a broken one may be cut short.
    task automatic build_report(input bit broken);
        field_kind_t kinds [$];
        int          cut;
        adv_bytes.delete();
        if ($urandom_range(99) < 85)
        begin
            kinds.push_back(FLD_UUID);
        end
        if ($urandom_range(99) < 85)
        begin
            kinds.insert($urandom_range(kinds.size()), FLD_MANUF);
        end
        repeat ($urandom_range(2))
        begin
            kinds.insert($urandom_range(kinds.size()),
                         field_kind_t'($urandom_range(FLD_EMPTY, FLD_OTHER)));
        end
        if (kinds.size() == 0)
        begin
            kinds.push_back(FLD_OTHER);
        end
        foreach (kinds[k])
        begin
            case (kinds[k])
                FLD_UUID:  add_uuid_field();
                FLD_MANUF: add_manuf_field();
                FLD_EMPTY: adv_bytes.push_back(8'h00);
                default:   add_other_field();
            endcase
        end
        if (broken)
        begin
            cut = $urandom_range(1, adv_bytes.size());
            while (adv_bytes.size() > cut)
            begin
                void'(adv_bytes.pop_back());
            end
        end
    endtask

    task automatic random_sequence();
        int roll;
        roll = $urandom_range(99);
        if (roll < 20)
        begin
            send_slot_op(opcode_t'($urandom_range(OP_FREE, OP_NONE)), 3'($urandom));
        end
        else
        begin
            pick_report_source();
            if (roll < 75)
            begin
                build_report(1'b0);
            end
            else if (roll < 90)
            begin
                build_report(1'b1);
            end
            else
            begin
                adv_bytes.delete();
                repeat ($urandom_range(1, 12))
                begin
                    adv_bytes.push_back(8'($urandom));
                end
            end
            send_report(8);
        end
    endtask

    // Wait until every result is in, then let the pipeline settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (answers_owed != 0);
        repeat (4)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_settings();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RSSI_THRESHOLD;
        cfg_data  <= {8'($urandom), cur_threshold};
        @(posedge clk);
        cfg_index <= CFG_WANTED_UUID;
        cfg_data  <= cur_uuid;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int target;

        repeat (7)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, with the settings left by reset
        rpt_rssi         = 8'sd127;
        rpt_address      = '1;
        rpt_address_type = 2'b11;
        send_slot_op(OP_READ, 3'd0);
        send_slot_op(OP_NONE, 3'd2);
        send_slot_op(OP_FREE, 3'd5);
        adv_bytes = '{8'h03, AD_UUID16_COMPLETE, 8'h00, 8'h00,
                      8'h05, AD_MANUF, 8'hDE, 8'hAD, 8'hBE, 8'hEF};
        send_report(0);
        send_slot_op(OP_READ, 3'd0);
        // signal equal to the threshold, report of one empty structure
        rpt_rssi         = RSSI_THRESHOLD_RESET;
        rpt_address      = '0;
        rpt_address_type = 2'b00;
        adv_bytes = '{8'h00};
        send_report(0);
        // uuid structure too short to hold a uuid
        rpt_rssi  = RSSI_THRESHOLD_RESET + 8'sd1;
        adv_bytes = '{8'h02, AD_UUID16_COMPLETE, 8'h00};
        send_report(0);
        // manufacturer structure too short to hold a serial
        adv_bytes = '{8'h03, AD_UUID16_COMPLETE, 8'h00, 8'h00, 8'h02, AD_MANUF, 8'h11};
        send_report(0);
        send_slot_op(OP_FREE, 3'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            case (p)
                0:
                begin
                    cur_threshold = -8'sd128;
                    cur_uuid      = 16'hFFFF;
                end
                1:
                begin
                    cur_threshold = 8'sd127;
                    cur_uuid      = 16'($urandom);
                end
                2:
                begin
                    cur_threshold = RSSI_THRESHOLD_RESET;
                    cur_uuid      = 16'h0000;
                end
                default:
                begin
                    cur_threshold = 8'(int'($urandom_range(60)) - 100);
                    cur_uuid      = 16'($urandom);
                end
            endcase
            write_settings();
            case (p % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 0;
                end
                1:
                begin
                    sender_idle_pct = 69;
                    stall_pct       = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 69;
                end
                default:
                begin
                    sender_idle_pct = 21;
                    stall_pct       = 21;
                end
            endcase
            target = words_sent + ITEMS_PER_PHASE;
            while (words_sent < target)
            begin
                random_sequence();
            end
        end

        drain_results();
        if (mismatches == 0 && answers_owed == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
